/* rtl/ecv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecv_pkg
// shared widths, stage counts, types and the velocity clip function for the
// two-dimensional elastic collision pipeline
// ----------------------------------------------------------------------------
package ecv_pkg;

    localparam int FIELD_W     = 32;
    localparam int IN_DATA_W   = 12 * FIELD_W;
    localparam int OUT_DATA_W  = 2 * FIELD_W;
    localparam int OUT_USER_W  = 2;
    localparam int DIFF_W      = FIELD_W + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int DOT_W       = SQ_W + 1;
    localparam int NUM_W       = 98;
    localparam int QUO_W       = 34;
    localparam int Q_W         = 32;
    localparam int Q_SHIFT     = 31;
    localparam int FRAC_SHIFT  = 30;
    localparam int PROD_W      = QUO_W + Q_W;
    localparam int DELTA_W     = 36;
    localparam int VEXT_W      = DELTA_W + 2;
    localparam int FRONT_STAGES = 6;
    localparam int BACK_STAGES  = 3;
    localparam int PIPE_STAGES  = FRONT_STAGES + QUO_W + BACK_STAGES;

    localparam logic signed [VEXT_W-1:0] VEL_MAX = 38'sd2147483647;
    localparam logic signed [VEXT_W-1:0] VEL_MIN = -38'sd2147483648;

    typedef struct packed {
        logic               ok;
        logic               neg_x;
        logic               neg_y;
        logic [FIELD_W-1:0] v1x;
        logic [FIELD_W-1:0] v1y;
    } side_t;

    typedef struct packed {
        logic               sat;
        logic [FIELD_W-1:0] vel;
    } vel_res_t;

    typedef struct packed {
        logic               sat;
        logic               contact;
        logic [FIELD_W-1:0] vy;
        logic [FIELD_W-1:0] vx;
    } out_t;

    function automatic vel_res_t apply_delta(logic [FIELD_W-1:0] v1,
                                             logic [DELTA_W-1:0] delta,
                                             logic neg);
        logic signed [VEXT_W-1:0] v1e;
        logic signed [VEXT_W-1:0] de;
        logic signed [VEXT_W-1:0] sum;
        vel_res_t                 r;
        v1e = {{(VEXT_W-FIELD_W){v1[FIELD_W-1]}}, v1};
        de  = {2'b00, delta};
        sum = neg ? v1e + de : v1e - de;
        r.sat = 1'b0;
        r.vel = sum[FIELD_W-1:0];
        if (sum > VEL_MAX)
        begin
            r.sat = 1'b1;
            r.vel = VEL_MAX[FIELD_W-1:0];
        end
        else if (sum < VEL_MIN)
        begin
            r.sat = 1'b1;
            r.vel = VEL_MIN[FIELD_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/elastic_collision_velocity_2d.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elastic_collision_velocity_2d
// new velocity of the first ball after a 2d elastic collision, q16.16 beats
// throughput: one beat per cycle while the output buffer is not full;
// 43 register stages incl. three parallel 34-stage dividers
// a two-entry output buffer keeps input open while one result waits
// reset: asynchronous, clears stage valid bits and the output buffer only
// ----------------------------------------------------------------------------
module elastic_collision_velocity_2d
    import ecv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // own_mass, own_pos_x, own_pos_y, own_vel_x, own_vel_y, own_radius,
    // other_mass, other_pos_x, other_pos_y, other_vel_x, other_vel_y, other_radius
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // new_vel_x, new_vel_y
    output logic [OUT_DATA_W-1:0] m_tdata,
    // in_contact, saturated
    output logic [OUT_USER_W-1:0] m_tuser
);

    localparam logic [PROD_W:0] ROUND_ADD = (PROD_W+1)'(1) << (FRAC_SHIFT - 1);

    logic                   en;
    logic [PIPE_STAGES-1:0] valid_reg;
    logic                   push;

    // input fields
    logic [FIELD_W-1:0] m1, x1, y1, v1x, v1y, r1, m2, x2, y2, v2x, v2y, r2;
    assign m1  = s_tdata[0*FIELD_W +: FIELD_W];
    assign x1  = s_tdata[1*FIELD_W +: FIELD_W];
    assign y1  = s_tdata[2*FIELD_W +: FIELD_W];
    assign v1x = s_tdata[3*FIELD_W +: FIELD_W];
    assign v1y = s_tdata[4*FIELD_W +: FIELD_W];
    assign r1  = s_tdata[5*FIELD_W +: FIELD_W];
    assign m2  = s_tdata[6*FIELD_W +: FIELD_W];
    assign x2  = s_tdata[7*FIELD_W +: FIELD_W];
    assign y2  = s_tdata[8*FIELD_W +: FIELD_W];
    assign v2x = s_tdata[9*FIELD_W +: FIELD_W];
    assign v2y = s_tdata[10*FIELD_W +: FIELD_W];
    assign r2  = s_tdata[11*FIELD_W +: FIELD_W];

    // stage 0: differences and sums
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dvx_reg, dvy_reg;
    logic [DIFF_W-1:0]        rs_reg, msum_reg0;
    logic [FIELD_W-1:0]       m2_reg0, v1x_reg0, v1y_reg0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= $signed({x1[FIELD_W-1], x1}) - $signed({x2[FIELD_W-1], x2});
            dy_reg    <= $signed({y1[FIELD_W-1], y1}) - $signed({y2[FIELD_W-1], y2});
            dvx_reg   <= $signed({v1x[FIELD_W-1], v1x}) - $signed({v2x[FIELD_W-1], v2x});
            dvy_reg   <= $signed({v1y[FIELD_W-1], v1y}) - $signed({v2y[FIELD_W-1], v2y});
            rs_reg    <= {1'b0, r1} + {1'b0, r2};
            msum_reg0 <= {1'b0, m1} + {1'b0, m2};
            m2_reg0   <= m2;
            v1x_reg0  <= v1x;
            v1y_reg0  <= v1y;
        end
    end

    // stage 1: products and magnitudes
    logic signed [SQ_W-1:0] sqx_next, sqy_next, pdx_next, pdy_next;
    logic [SQ_W-1:0]        rs2_next;
    logic [DIFF_W-1:0]      dx_neg, dy_neg;
    logic signed [SQ_W-1:0] sqx_reg, sqy_reg, pdx_reg, pdy_reg;
    logic [SQ_W-1:0]        rs2_reg;
    logic [DIFF_W-1:0]      adx_reg1, ady_reg1, msum_reg1;
    logic                   sdx_reg1, sdy_reg1;
    logic [FIELD_W-1:0]     m2_reg1, v1x_reg1, v1y_reg1;

    assign sqx_next = dx_reg * dx_reg;
    assign sqy_next = dy_reg * dy_reg;
    assign pdx_next = dvx_reg * dx_reg;
    assign pdy_next = dvy_reg * dy_reg;
    assign rs2_next = rs_reg * rs_reg;
    assign dx_neg   = -dx_reg;
    assign dy_neg   = -dy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            pdx_reg   <= pdx_next;
            pdy_reg   <= pdy_next;
            rs2_reg   <= rs2_next;
            adx_reg1  <= dx_reg[DIFF_W-1] ? dx_neg : dx_reg;
            ady_reg1  <= dy_reg[DIFF_W-1] ? dy_neg : dy_reg;
            sdx_reg1  <= dx_reg[DIFF_W-1];
            sdy_reg1  <= dy_reg[DIFF_W-1];
            msum_reg1 <= msum_reg0;
            m2_reg1   <= m2_reg0;
            v1x_reg1  <= v1x_reg0;
            v1y_reg1  <= v1y_reg0;
        end
    end

    // stage 2: squared distance, dot product, contact test
    logic [SQ_W-1:0]         d2_next;
    logic signed [DOT_W-1:0] dot_next;
    logic                    ok_next;
    logic [SQ_W-1:0]         d2_reg2;
    logic signed [DOT_W-1:0] dot_reg;
    logic                    ok_reg2;
    logic [DIFF_W-1:0]       adx_reg2, ady_reg2, msum_reg2;
    logic                    sdx_reg2, sdy_reg2;
    logic [FIELD_W-1:0]      m2_reg2, v1x_reg2, v1y_reg2;

    assign d2_next  = $unsigned(sqx_reg) + $unsigned(sqy_reg);
    assign dot_next = $signed({pdx_reg[SQ_W-1], pdx_reg}) + $signed({pdy_reg[SQ_W-1], pdy_reg});
    assign ok_next  = (d2_next <= rs2_reg) && (d2_next != '0) && (msum_reg1 != '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg2   <= d2_next;
            dot_reg   <= dot_next;
            ok_reg2   <= ok_next;
            adx_reg2  <= adx_reg1;
            ady_reg2  <= ady_reg1;
            sdx_reg2  <= sdx_reg1;
            sdy_reg2  <= sdy_reg1;
            msum_reg2 <= msum_reg1;
            m2_reg2   <= m2_reg1;
            v1x_reg2  <= v1x_reg1;
            v1y_reg2  <= v1y_reg1;
        end
    end

    // stage 3: dot magnitude and component signs
    logic [DOT_W-1:0]  dot_neg;
    logic              dneg;
    logic [SQ_W-1:0]   dmag_reg, d2_reg3;
    logic [DIFF_W-1:0] adx_reg3, ady_reg3, msum_reg3;
    logic [FIELD_W-1:0] m2_reg3;
    side_t             side_reg3;

    assign dot_neg = -dot_reg;
    assign dneg    = dot_reg[DOT_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg        <= dneg ? dot_neg[SQ_W-1:0] : dot_reg[SQ_W-1:0];
            d2_reg3         <= d2_reg2;
            adx_reg3        <= adx_reg2;
            ady_reg3        <= ady_reg2;
            msum_reg3       <= msum_reg2;
            m2_reg3         <= m2_reg2;
            side_reg3.ok    <= ok_reg2;
            side_reg3.neg_x <= dneg ^ sdx_reg2;
            side_reg3.neg_y <= dneg ^ sdy_reg2;
            side_reg3.v1x   <= v1x_reg2;
            side_reg3.v1y   <= v1y_reg2;
        end
    end

    // stage 4: partial products of |dot| * |d component|
    logic [SQ_W-1:0]    plx_reg, phx_reg, ply_reg, phy_reg, d2_reg4;
    logic [DIFF_W-1:0]  msum_reg4;
    logic [FIELD_W-1:0] m2_reg4;
    side_t              side_reg4;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plx_reg   <= dmag_reg[DIFF_W-1:0] * adx_reg3;
            phx_reg   <= dmag_reg[SQ_W-1:DIFF_W] * adx_reg3;
            ply_reg   <= dmag_reg[DIFF_W-1:0] * ady_reg3;
            phy_reg   <= dmag_reg[SQ_W-1:DIFF_W] * ady_reg3;
            d2_reg4   <= d2_reg3;
            msum_reg4 <= msum_reg3;
            m2_reg4   <= m2_reg3;
            side_reg4 <= side_reg3;
        end
    end

    // stage 5: dividends and divisors
    logic [SQ_W+DIFF_W-1:0] numx_sum, numy_sum;
    logic [NUM_W-1:0]       numx_reg, numy_reg, qnum_reg;
    logic [SQ_W-1:0]        d2_reg5, qden_reg;
    side_t                  side_reg5;

    assign numx_sum = {{DIFF_W{1'b0}}, plx_reg} + {phx_reg, {DIFF_W{1'b0}}};
    assign numy_sum = {{DIFF_W{1'b0}}, ply_reg} + {phy_reg, {DIFF_W{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg  <= numx_sum[NUM_W-1:0];
            numy_reg  <= numy_sum[NUM_W-1:0];
            qnum_reg  <= NUM_W'({m2_reg4, {Q_SHIFT{1'b0}}});
            qden_reg  <= SQ_W'(msum_reg4);
            d2_reg5   <= d2_reg4;
            side_reg5 <= side_reg4;
        end
    end

    // divider stages
    logic [QUO_W-1:0] tx_quo, ty_quo, q_quo;
    side_t            side_div_reg [QUO_W];

    ecv_div #(.N_W(NUM_W), .D_W(SQ_W), .Q_BITS(QUO_W)) u_div_x
    (
        .clk (clk),
        .en  (en),
        .num (numx_reg),
        .den (d2_reg5),
        .quo (tx_quo)
    );

    ecv_div #(.N_W(NUM_W), .D_W(SQ_W), .Q_BITS(QUO_W)) u_div_y
    (
        .clk (clk),
        .en  (en),
        .num (numy_reg),
        .den (d2_reg5),
        .quo (ty_quo)
    );

    ecv_div #(.N_W(NUM_W), .D_W(SQ_W), .Q_BITS(QUO_W)) u_div_q
    (
        .clk (clk),
        .en  (en),
        .num (qnum_reg),
        .den (qden_reg),
        .quo (q_quo)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_div_reg[0] <= side_reg5;
            for (int k = 1; k < QUO_W; k++)
            begin
                side_div_reg[k] <= side_div_reg[k-1];
            end
        end
    end

    // back stage 0: scale by mass ratio
    logic [PROD_W-1:0] prodx_reg, prody_reg;
    side_t             side_reg6;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prodx_reg <= tx_quo * q_quo[Q_W-1:0];
            prody_reg <= ty_quo * q_quo[Q_W-1:0];
            side_reg6 <= side_div_reg[QUO_W-1];
        end
    end

    // back stage 1: round half away from zero
    logic [PROD_W:0]    rx_sum, ry_sum;
    logic [DELTA_W-1:0] deltax_reg, deltay_reg;
    side_t              side_reg7;

    assign rx_sum = {1'b0, prodx_reg} + ROUND_ADD;
    assign ry_sum = {1'b0, prody_reg} + ROUND_ADD;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deltax_reg <= rx_sum[FRAC_SHIFT +: DELTA_W];
            deltay_reg <= ry_sum[FRAC_SHIFT +: DELTA_W];
            side_reg7  <= side_reg6;
        end
    end

    // back stage 2: apply, clip, select
    vel_res_t resx, resy;
    out_t     res_next, res_reg;

    assign resx = apply_delta(side_reg7.v1x, deltax_reg, side_reg7.neg_x);
    assign resy = apply_delta(side_reg7.v1y, deltay_reg, side_reg7.neg_y);

    always_comb
    begin
        res_next.contact = side_reg7.ok;
        res_next.sat     = side_reg7.ok & (resx.sat | resy.sat);
        res_next.vx      = side_reg7.ok ? resx.vel : side_reg7.v1x;
        res_next.vy      = side_reg7.ok ? resy.vel : side_reg7.v1y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_STAGES-2:0], s_tvalid};
        end
    end

    // two-entry output buffer
    out_t head_reg, skid_reg;
    logic head_valid_reg, skid_valid_reg;
    logic pop;

    assign en   = !skid_valid_reg;
    assign push = en && valid_reg[PIPE_STAGES-1];
    assign pop  = head_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!head_valid_reg || pop)
        begin
            head_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!head_valid_reg || pop)
        begin
            head_reg <= skid_valid_reg ? skid_reg : res_reg;
        end
        else if (push)
        begin
            skid_reg <= res_reg;
        end
    end

    assign s_tready = en;
    assign m_tvalid = head_valid_reg;
    assign m_tdata  = {head_reg.vy, head_reg.vx};
    assign m_tuser  = {head_reg.sat, head_reg.contact};

    // checks
    a_sat_needs_contact: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> !m_tuser[1])
        else $error("saturation flagged without contact");

    a_skid_implies_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held with empty head");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted beat missing from first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

/* rtl/ecv_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecv_div
// pipelined restoring divider, one quotient bit per stage, common stall enable
// ----------------------------------------------------------------------------
module ecv_div
    import ecv_pkg::*;
#(
    parameter int N_W = 98,
    parameter int D_W = 66,
    parameter int Q_BITS = 34
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [N_W-1:0]    num,
    input  logic [D_W-1:0]    den,
    output logic [Q_BITS-1:0] quo
);

    logic [D_W-1:0]    rem_reg [Q_BITS];
    logic [Q_BITS-1:0] qn_reg  [Q_BITS];
    logic [D_W-1:0]    den_reg [Q_BITS];

    genvar k;
    generate
        for (k = 0; k < Q_BITS; k++)
        begin : g_stage
            logic [D_W-1:0]    rem_in;
            logic [Q_BITS-1:0] qn_in;
            logic [D_W-1:0]    den_in;
            logic [D_W:0]      trial;
            logic [D_W:0]      diff;
            logic              ge;
            logic [D_W-1:0]    rem_next;
            logic [Q_BITS-1:0] qn_next;

            if (k == 0)
            begin : g_first
                assign rem_in = D_W'(num >> Q_BITS);
                assign qn_in  = num[Q_BITS-1:0];
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign qn_in  = qn_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            assign trial    = {rem_in, qn_in[Q_BITS-1]};
            assign diff     = trial - {1'b0, den_in};
            assign ge       = trial >= {1'b0, den_in};
            assign rem_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            assign qn_next  = {qn_in[Q_BITS-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    qn_reg[k]  <= qn_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = qn_reg[Q_BITS-1];

endmodule
`default_nettype wire

/* tb/elastic_collision_velocity_2d_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_collision_velocity_2d_test
// streams ball pairs into the collision pipeline and checks each output beat
// against a fixed-point collision predictor kept in a small scoreboard
// ----------------------------------------------------------------------------
class collision_scoreboard;
    typedef struct {
        logic [31:0] vx;
        logic [31:0] vy;
        logic        contact;
        logic        sat;
    } vel_update_t;

    vel_update_t pending[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    static function logic [31:0] clip_vel(logic signed [127:0] v, inout logic sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    static function logic [31:0] axis_update(logic signed [31:0] vc,
                                             logic signed [63:0] dc,
                                             logic [127:0] dot_mag, logic dot_neg,
                                             logic [127:0] d2, logic [63:0] q,
                                             inout logic sat);
        logic [127:0]        dc_mag;
        logic [127:0]        t;
        logic [127:0]        prod;
        logic [63:0]         delta;
        logic signed [127:0] sd;
        dc_mag = dc < 0 ? 128'(-dc) : 128'(dc);
        t      = (dot_mag * dc_mag) / d2;
        t      = {64'd0, t[63:0]};
        prod   = t * {64'd0, q} + (128'd1 << 29);
        delta  = prod[93:30];
        sd     = $signed({64'd0, delta});
        if (dot_neg != (dc < 0))
            sd = -sd;
        return clip_vel(128'(vc) - sd, sat);
    endfunction

    function void note_pair(logic [383:0] d);
        vel_update_t        e;
        logic [63:0]        m1, m2, r1, r2, msum, rs, q;
        logic signed [63:0] x1, y1, v1x, v1y, x2, y2, v2x, v2y, dx, dy, dvx, dvy;
        logic [127:0]       d2, rs2, dmag;
        logic signed [127:0] dot;
        logic               sat;
        m1  = d[31:0];
        x1  = $signed(d[63:32]);
        y1  = $signed(d[95:64]);
        v1x = $signed(d[127:96]);
        v1y = $signed(d[159:128]);
        r1  = d[191:160];
        m2  = d[223:192];
        x2  = $signed(d[255:224]);
        y2  = $signed(d[287:256]);
        v2x = $signed(d[319:288]);
        v2y = $signed(d[351:320]);
        r2  = d[383:352];
        dx = x1 - x2;
        dy = y1 - y2;
        dvx = v1x - v2x;
        dvy = v1y - v2y;
        rs = r1 + r2;
        msum = m1 + m2;
        d2 = $unsigned(128'($signed(dx)) * 128'($signed(dx)))
           + $unsigned(128'($signed(dy)) * 128'($signed(dy)));
        rs2 = {64'd0, rs} * {64'd0, rs};
        e.vx = v1x[31:0];
        e.vy = v1y[31:0];
        e.contact = 1'b0;
        e.sat = 1'b0;
        if (d2 <= rs2 && d2 != 0 && msum != 0)
        begin
            q    = (m2 << 31) / msum;
            dot  = 128'($signed(dvx)) * 128'($signed(dx))
                 + 128'($signed(dvy)) * 128'($signed(dy));
            dmag = dot < 0 ? -dot : dot;
            sat  = 1'b0;
            e.vx = axis_update(v1x[31:0], dx, dmag, dot < 0, d2, q, sat);
            e.vy = axis_update(v1y[31:0], dy, dmag, dot < 0, d2, q, sat);
            e.contact = 1'b1;
            e.sat = sat;
        end
        pending.push_back(e);
    endfunction

    function void check_update(logic [63:0] data, logic [1:0] user);
        vel_update_t e;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected beat data=%h user=%b", data, user);
            return;
        end
        e = pending.pop_front();
        if (data !== {e.vy, e.vx} || user !== {e.sat, e.contact})
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp vx=%h vy=%h c=%b s=%b, got vx=%h vy=%h c=%b s=%b",
                         e.vx, e.vy, e.contact, e.sat, data[31:0], data[63:32],
                         user[0], user[1]);
        end
    endfunction
endclass

module elastic_collision_velocity_2d_test;
    import ecv_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    collision_scoreboard sb = new();
    bit calm = 1'b0;
    bit sending_done = 1'b0;

    elastic_collision_velocity_2d dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_pair(s_tdata);
        if (m_tvalid && m_tready)
            sb.check_update(m_tdata, m_tuser);
    end

    initial
    begin
        int gap;
        @(negedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
        end
    end

    task automatic send_pair(logic [383:0] d);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'hffffffff;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [383:0] pack_pair(logic [31:0] m1, x1, y1, vx1, vy1, r1,
                                               logic [31:0] m2, x2, y2, vx2, vy2, r2);
        return {r2, vy2, vx2, y2, x2, m2, r1, vy1, vx1, y1, x1, m1};
    endfunction

    // touching pair: centers close relative to the radii
    function automatic logic [383:0] touching_pair();
        logic [31:0] x1, y1, span, r;
        int          shift;
        shift = $urandom_range(4, 30);
        span  = 32'($urandom()) >> shift;
        x1 = $urandom();
        y1 = $urandom();
        r  = span + ($urandom() >> (shift + 1));
        return pack_pair($urandom() >> $urandom_range(0, 16), x1, y1, rnd_word(), rnd_word(),
                         r, $urandom() >> $urandom_range(0, 16),
                         x1 + $signed(span) - $signed(span >> 1),
                         y1 - $signed(span >> 2), rnd_word(), rnd_word(), r);
    endfunction

    initial
    begin
        logic [383:0] d;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // directed
        send_pair('0);
        send_pair('1);
        send_pair(pack_pair(32'h10000, 0, 0, 32'h10000, 0, 32'h10000,
                            32'h10000, 32'h10000, 0, 0, 0, 32'h10000));
        send_pair(pack_pair(32'h10000, 0, 0, 32'h10000, 0, 32'h10000,
                            32'h10000, 32'h30000, 0, 0, 0, 32'h10000));
        send_pair(pack_pair(32'h10000, 5, 5, 32'h10000, 7, 32'h10000,
                            32'h10000, 5, 5, 0, 0, 32'h10000));
        send_pair(pack_pair(0, 0, 0, 32'h10000, 0, 32'h10000, 0, 32'h8000, 0, 0, 0,
                            32'h10000));
        send_pair(pack_pair(32'h1, 0, 0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                            32'hffffffff, 32'h1, 32'h1, 32'h80000000, 32'h7fffffff,
                            32'hffffffff));
        send_pair(pack_pair(32'hffffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'hffffffff, 32'hffffffff, 32'h7fffffff,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff));
        send_pair(pack_pair(32'hffffffff, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000,
                            32'hffffffff, 32'hffffffff, 32'h80000000, 0, 32'h80000000,
                            32'h7fffffff, 32'hffffffff));
        send_pair(pack_pair(32'h10000, 0, 0, 32'h7fff0000, 0, 32'h10000,
                            32'hffffffff, 1, 0, 32'h80000000, 0, 32'h10000));
        send_pair(pack_pair(32'h10000, 0, 0, 0, 32'h10000, 32'h8000,
                            32'h20000, 0, 32'h10000, 0, 32'hffff0000, 32'h8000));
        for (int i = 0; i < 10; i++)
            send_pair(touching_pair());
        // drain with the sender held off
        s_tvalid <= 1'b0;
        wait (sb.pending.size() == 0);
        @(negedge clk);
        for (int i = 0; i < 900; i++)
        begin
            if (i == 750)
                calm = 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                for (int k = 0; k < 12; k++)
                    d[k*32 +: 32] = rnd_word();
                send_pair(d);
            end
            else
                send_pair(touching_pair());
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    initial
    begin
        wait (sending_done);
        wait (sb.pending.size() == 0);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule
